// File: rtl/escape_frame_parser_crc16_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ESCAPE_FRAME_PARSER_CRC16_TOP_DEFINES_SVH
`define ESCAPE_FRAME_PARSER_CRC16_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("efp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define EFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("efp assertion failed");

`endif

// File: rtl/efp_pkg.sv
`default_nettype none

package efp_pkg;

   // Configuration register indexes
   localparam logic CSR_START_BYTE    = 1'b0;
   localparam logic CSR_STALL_TIMEOUT = 1'b1;

   // Reset values and fixed constants
   localparam logic [7:0]  START_BYTE_RESET    = 8'h2F;
   localparam logic [31:0] STALL_TIMEOUT_RESET = 32'd250000;
   localparam logic [8:0]  MAX_PARAMS          = 9'd256;
   localparam logic [15:0] CRC_POLY            = 16'h1021;

   // Item opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // Parser phases
   localparam logic [2:0] PH_WAIT    = 3'd0;
   localparam logic [2:0] PH_CMD     = 3'd1;
   localparam logic [2:0] PH_ADDR_HI = 3'd2;
   localparam logic [2:0] PH_ADDR_LO = 3'd3;
   localparam logic [2:0] PH_LEN     = 3'd4;
   localparam logic [2:0] PH_PARAM   = 3'd5;
   localparam logic [2:0] PH_CRC_HI  = 3'd6;
   localparam logic [2:0] PH_CRC_LO  = 3'd7;

   // Result event codes
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_PARAM   = 3'd1;
   localparam logic [2:0] EV_GOOD    = 3'd2;
   localparam logic [2:0] EV_CRC_ERR = 3'd3;
   localparam logic [2:0] EV_STALL   = 3'd4;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  data_byte;
      logic [31:0] time_now_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  frame_command;
      logic [15:0] frame_address;
      logic [8:0]  frame_length;
      logic [7:0]  param_position;
      logic [7:0]  param_data;
      logic [31:0] crc_fail_total;
      logic [31:0] stall_total;
   } rsp_type;

   // CRC-16/XMODEM update by one byte, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/escape_frame_parser_crc16_top.sv
// An accepted item is held in the input register, then its result is registered on rsp_data.
// Throughput: one item per cycle unless rsp_ready stalls; one phase step, at most one CRC byte update, per item.
// While a finished result waits for rsp_ready, the input register takes one more item.
// Reset (synchronous, active high) returns the parser to waiting for the start byte,
// clears counters and frame fields, and reloads start byte 0x2F and timeout 250000 us.
`default_nettype none

module escape_frame_parser_crc16_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire efp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output efp_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata
);

   // Configuration
   logic [7:0]  start_byte_ff, start_byte_in;
   logic [31:0] timeout_ff, timeout_in;

   // Input stage
   logic             in_valid_ff, in_valid_in;
   efp_pkg::req_type in_ff, in_in;

   // Parser state
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] address_ff, address_in;
   logic [8:0]  length_ff, length_in;
   logic [8:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  rcv_hi_ff, rcv_hi_in;
   logic        seen_ff, seen_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] crc_fail_ff, crc_fail_in;
   logic [31:0] stall_ff, stall_in;

   // Result stage
   logic             rsp_valid_ff, rsp_valid_in;
   efp_pkg::rsp_type rsp_ff, rsp_in;

   logic        advance;
   logic        fire;
   logic [2:0]  ev;
   logic [7:0]  pos;
   logic [7:0]  pdata;
   logic [7:0]  b;
   logic [15:0] crc_upd;
   logic [8:0]  count_inc;
   logic [31:0] elapsed;

   // Handshake: result slot frees when taken, input slot when it moves on
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      in_valid_in  = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_in        = (req_valid && req_ready) ? req_data : in_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Configuration writes
   always_comb begin
      start_byte_in = start_byte_ff;
      timeout_in    = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            efp_pkg::CSR_START_BYTE:    start_byte_in = csr_wdata[7:0];
            efp_pkg::CSR_STALL_TIMEOUT: timeout_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   assign b         = in_ff.data_byte;
   assign crc_upd   = efp_pkg::crc16_byte((phase_ff == efp_pkg::PH_WAIT) ? 16'h0000 : crc_ff, b);
   assign count_inc = count_ff + 9'd1;
   assign elapsed   = in_ff.time_now_us - last_time_ff;

   // One parser step per item
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      address_in   = address_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      rcv_hi_in    = rcv_hi_ff;
      seen_in      = seen_ff;
      last_time_in = last_time_ff;
      crc_fail_in  = crc_fail_ff;
      stall_in     = stall_ff;
      ev           = efp_pkg::EV_NONE;
      pos          = 8'd0;
      pdata        = 8'd0;
      if (fire) begin
         if (in_ff.opcode == efp_pkg::OP_BYTE) begin
            seen_in = 1'b1;
            unique case (phase_ff)
               efp_pkg::PH_WAIT: begin
                  if (b == start_byte_ff) begin
                     crc_in   = crc_upd;
                     phase_in = efp_pkg::PH_CMD;
                  end
               end
               efp_pkg::PH_CMD: begin
                  command_in = b;
                  crc_in     = crc_upd;
                  phase_in   = efp_pkg::PH_ADDR_HI;
               end
               efp_pkg::PH_ADDR_HI: begin
                  address_in = {b, 8'h00};
                  crc_in     = crc_upd;
                  phase_in   = efp_pkg::PH_ADDR_LO;
               end
               efp_pkg::PH_ADDR_LO: begin
                  address_in = {address_ff[15:8], b};
                  crc_in     = crc_upd;
                  phase_in   = efp_pkg::PH_LEN;
               end
               efp_pkg::PH_LEN: begin
                  length_in = (b == 8'd0) ? efp_pkg::MAX_PARAMS : {1'b0, b};
                  crc_in    = crc_upd;
                  count_in  = 9'd0;
                  phase_in  = efp_pkg::PH_PARAM;
               end
               efp_pkg::PH_PARAM: begin
                  ev       = efp_pkg::EV_PARAM;
                  pos      = count_ff[7:0];
                  pdata    = b;
                  crc_in   = crc_upd;
                  count_in = count_inc;
                  if (count_inc >= length_ff) phase_in = efp_pkg::PH_CRC_HI;
               end
               efp_pkg::PH_CRC_HI: begin
                  rcv_hi_in = b;
                  phase_in  = efp_pkg::PH_CRC_LO;
               end
               efp_pkg::PH_CRC_LO: begin
                  if ({rcv_hi_ff, b} == crc_ff) begin
                     ev = efp_pkg::EV_GOOD;
                  end else begin
                     ev          = efp_pkg::EV_CRC_ERR;
                     crc_fail_in = crc_fail_ff + 32'd1;
                  end
                  phase_in = efp_pkg::PH_WAIT;
                  count_in = 9'd0;
                  crc_in   = 16'h0000;
               end
               default: ;
            endcase
         end else if (phase_ff != efp_pkg::PH_WAIT) begin
            // Poll: first poll after progress rearms the timer, else check the timeout
            if (seen_ff) begin
               seen_in      = 1'b0;
               last_time_in = in_ff.time_now_us;
            end else if (elapsed > timeout_ff) begin
               ev       = efp_pkg::EV_STALL;
               stall_in = stall_ff + 32'd1;
               phase_in = efp_pkg::PH_WAIT;
               count_in = 9'd0;
               crc_in   = 16'h0000;
            end
         end
      end
   end

   // Result item from the state after the step
   always_comb begin
      rsp_in = rsp_ff;
      if (fire) begin
         rsp_in.event_res      = ev;
         rsp_in.frame_command  = command_in;
         rsp_in.frame_address  = address_in;
         rsp_in.frame_length   = length_in;
         rsp_in.param_position = pos;
         rsp_in.param_data     = pdata;
         rsp_in.crc_fail_total = crc_fail_in;
         rsp_in.stall_total    = stall_in;
      end
   end

   // Control and visible state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= efp_pkg::START_BYTE_RESET;
         timeout_ff    <= efp_pkg::STALL_TIMEOUT_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= efp_pkg::PH_WAIT;
         command_ff    <= 8'd0;
         address_ff    <= 16'd0;
         length_ff     <= 9'd0;
         count_ff      <= 9'd0;
         crc_ff        <= 16'd0;
         rcv_hi_ff     <= 8'd0;
         seen_ff       <= 1'b0;
         last_time_ff  <= 32'd0;
         crc_fail_ff   <= 32'd0;
         stall_ff      <= 32'd0;
      end else begin
         start_byte_ff <= start_byte_in;
         timeout_ff    <= timeout_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         command_ff    <= command_in;
         address_ff    <= address_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         rcv_hi_ff     <= rcv_hi_in;
         seen_ff       <= seen_in;
         last_time_ff  <= last_time_in;
         crc_fail_ff   <= crc_fail_in;
         stall_ff      <= stall_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// File: rtl/efp_checker.sv
`default_nettype none
`include "escape_frame_parser_crc16_top_defines.svh"

module efp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire efp_pkg::rsp_type rsp_data
);

   logic rsp_stall;
   logic param_ev;
   logic frame_ev;
   logic param_clear;
   logic len_ok;
   logic pos_ok;

   // Result item classes and field checks
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign param_ev    = rsp_valid && (rsp_data.event_res == efp_pkg::EV_PARAM);
   assign frame_ev    = param_ev ||
                        (rsp_valid && ((rsp_data.event_res == efp_pkg::EV_GOOD) ||
                                       (rsp_data.event_res == efp_pkg::EV_CRC_ERR)));
   assign param_clear = (rsp_data.param_position == 8'd0) && (rsp_data.param_data == 8'd0);
   assign len_ok      = (rsp_data.frame_length != 9'd0) &&
                        (rsp_data.frame_length <= efp_pkg::MAX_PARAMS);
   assign pos_ok      = {1'b0, rsp_data.param_position} < rsp_data.frame_length;

   // A stalled result item holds
   `EFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // No result item and an open input right after reset
   `EFP_ASSERT_SAME(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid && req_ready)

   // Parameter fields are zero outside parameter events
   `EFP_ASSERT_SAME(a_param_zero, clock, reset, rsp_valid && !param_ev, param_clear)

   // Events inside a frame carry a valid length
   `EFP_ASSERT_SAME(a_len_range, clock, reset, frame_ev, len_ok)

   // Parameter index stays below the frame length
   `EFP_ASSERT_SAME(a_pos_range, clock, reset, param_ev, pos_ok)

endmodule

bind escape_frame_parser_crc16_top efp_checker u_efp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
